FILE: hw/rtl/ampq_pkg.sv
package ampq_pkg;

    // capacity of the store
    localparam int DEPTH  = 8;
    localparam int VAL_W  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OUT_CNT_W = 4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REMOVED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic       load_in;
        logic       set_status;
        logic [1:0] status;
        logic       ins_write;
        logic       scan_start;
        logic       scan_step;
        logic       shift_start;
        logic       shift_step;
        logic       dec_held;
        logic       load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op;
        logic full;
        logic empty;
        logic scan_last;
        logic shift_done;
        logic out_busy;
    } sts_t;

endpackage

FILE: hw/rtl/ampq_ram.sv
module ampq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ampq_ctrl.sv
module ampq_ctrl import ampq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHSET  = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.op == OP_INSERT) begin
                    cmd.set_status = 1'b1;
                    if (sts.full) begin
                        cmd.status = ST_FULL;
                    end else begin
                        cmd.status    = ST_INSERTED;
                        cmd.ins_write = 1'b1;
                    end
                    state_next = S_DONE;
                end else if (sts.empty) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_EMPTY;
                    state_next     = S_DONE;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_SHSET;
                end
            end
            S_SHSET: begin
                cmd.shift_start = 1'b1;
                state_next      = S_SHIFT;
            end
            S_SHIFT: begin
                if (sts.shift_done) begin
                    cmd.dec_held   = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_REMOVED;
                    state_next     = S_DONE;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ampq_dp.sv
module ampq_dp import ampq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic             in_op,
    input  logic [VAL_W-1:0] in_value,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,
    output logic [1:0]       m_tuser
);

    localparam int CX_W = CNT_W + OUT_CNT_W;

    logic              op_reg, op_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [VAL_W-1:0]  best_val_reg, best_val_next;
    logic [ADDR_W-1:0] best_idx_reg, best_idx_next;
    logic [1:0]        status_reg, status_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [VAL_W-1:0]     out_value_reg, out_value_next;
    logic [OUT_CNT_W-1:0] out_count_reg, out_count_next;

    logic [CNT_W-1:0]  idx_m1;
    logic [CNT_W-1:0]  idx_m2;
    logic [CX_W-1:0]   held_ext;
    logic              idx_lt_held;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
    logic [VAL_W-1:0]  rdata;

    ampq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign idx_m1      = idx_reg - CNT_W'(1);
    assign idx_m2      = idx_reg - CNT_W'(2);
    assign idx_lt_held = idx_reg < held_reg;
    assign held_ext    = CX_W'(held_reg);

    // write port: tail append on insert, one place down while compacting
    assign we    = cmd.ins_write | (cmd.shift_step & pend_reg);
    assign waddr = cmd.ins_write ? held_reg[ADDR_W-1:0] : idx_m2[ADDR_W-1:0];
    assign wdata = cmd.ins_write ? val_reg : rdata;
    assign raddr = cmd.scan_start ? '0 : idx_reg[ADDR_W-1:0];

    always_comb begin
        op_next         = op_reg;
        val_next        = val_reg;
        held_next       = held_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;

        if (cmd.load_in) begin
            op_next  = in_op;
            val_next = in_value;
        end
        if (cmd.set_status) begin
            status_next = cmd.status;
        end
        if (cmd.ins_write) begin
            held_next = held_reg + CNT_W'(1);
        end
        if (cmd.dec_held) begin
            held_next = held_reg - CNT_W'(1);
        end

        // scan: rdata holds entry idx-1; strict less keeps the oldest on ties
        if (cmd.scan_start) begin
            idx_next = CNT_W'(1);
        end
        if (cmd.scan_step) begin
            if ((idx_reg == CNT_W'(1)) || ($signed(rdata) < $signed(best_val_reg))) begin
                best_val_next = rdata;
                best_idx_next = idx_m1[ADDR_W-1:0];
            end
            if (idx_lt_held) begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end

        if (cmd.shift_start) begin
            idx_next  = CNT_W'(best_idx_reg) + CNT_W'(1);
            pend_next = 1'b0;
        end
        if (cmd.shift_step) begin
            pend_next = idx_lt_held;
            if (idx_lt_held) begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end

        if (cmd.load_out) begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_value_next  = (status_reg == ST_REMOVED) ? best_val_reg : '0;
            out_count_next  = held_ext[OUT_CNT_W-1:0];
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            held_reg      <= held_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
        op_reg         <= op_next;
        val_reg        <= val_next;
        best_val_reg   <= best_val_next;
        best_idx_reg   <= best_idx_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
    end

    assign sts.op         = op_reg;
    assign sts.full       = held_reg >= CNT_W'(DEPTH);
    assign sts.empty      = held_reg == '0;
    assign sts.scan_last  = !idx_lt_held;
    assign sts.shift_done = !pend_reg && !idx_lt_held;
    assign sts.out_busy   = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'b0000, out_count_reg, out_value_reg};

endmodule

FILE: hw/rtl/array_min_priority_queue_top.sv
// Channel  | Dir | tdata                          | tuser        | Transaction
// ---------+-----+--------------------------------+--------------+--------------------------
// s_ (op)  | in  | [31:0] value                   | [0] opcode   | one insert or remove-min
// m_ (res) | out | [31:0] removed_value,[35:32] count | [1:0] status | one result per operation
//
// Sequence: insert, full and empty pass through decode and a done state before the
// result. Remove-min scans with one RAM read per entry, then compacts with a priming
// read, one read/write pair per later entry and a closing step (single RAM port each).
// Reset: aresetn low clears the count and control; stored entries are not cleared.
// Stalls: one result may wait in the output register while the next operation is
// accepted; the block only holds off completing that operation until it drains.
module array_min_priority_queue_top import ampq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    // operation channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [VAL_W-1:0] s_tdata,   // [31:0] value
    input  logic             s_tuser,   // [0] opcode: 0 insert, 1 remove-min
    // result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,   // [31:0] removed_value, [35:32] count, rest zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: decode, scan for minimum, compact, hand off
    ampq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // entry store, count, running minimum and output register
    ampq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_op    (s_tuser),
        .in_value (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
